// ----- rtl/core/scd_pkg.sv -----
// Package for the set-1 scancode to ASCII decoder.
// Holds key numbers, queue types and the fixed keymap; depends on nothing.
`default_nettype none

package scd_pkg;

  localparam int unsigned KEY_COUNT     = 128;
  localparam int unsigned KEY_W         = 7;
  localparam int unsigned CHAR_W        = 7;
  localparam int unsigned CODE_W        = 8;
  localparam int unsigned DEF_QUEUE_DEPTH = 4;

  localparam logic [KEY_W-1:0] KEY_LSHIFT = 7'h2A;
  localparam logic [KEY_W-1:0] KEY_RSHIFT = 7'h36;
  localparam logic [KEY_W-1:0] KEY_CAPS   = 7'h3A;

  // One keymap row: plain and shifted character plus class flags.
  typedef struct packed {
    logic [CHAR_W-1:0] plain;
    logic [CHAR_W-1:0] shifted;
    logic              is_char;
    logic              has_shift;
    logic              is_letter;
  } keymap_row_t;

  // Character moving from the front through the queue to the back.
  typedef struct packed {
    logic              valid;
    logic [CHAR_W-1:0] character;
  } char_item_t;

  function automatic keymap_row_t key_sym(input logic [CHAR_W-1:0] p,
                                          input logic [CHAR_W-1:0] s);
    keymap_row_t r;
    r = '{plain: p, shifted: s, is_char: 1'b1, has_shift: 1'b1, is_letter: 1'b0};
    return r;
  endfunction

  function automatic keymap_row_t key_ltr(input logic [CHAR_W-1:0] p,
                                          input logic [CHAR_W-1:0] s);
    keymap_row_t r;
    r = '{plain: p, shifted: s, is_char: 1'b1, has_shift: 1'b1, is_letter: 1'b1};
    return r;
  endfunction

  function automatic keymap_row_t key_one(input logic [CHAR_W-1:0] p);
    keymap_row_t r;
    r = '{plain: p, shifted: '0, is_char: 1'b1, has_shift: 1'b0, is_letter: 1'b0};
    return r;
  endfunction

  function automatic keymap_row_t keymap_lookup(input logic [KEY_W-1:0] key);
    keymap_row_t r;
    r = '0;
    case (key)
      7'h02: r = key_sym(7'h31, 7'h21); // 1 !
      7'h03: r = key_sym(7'h32, 7'h40); // 2 @
      7'h04: r = key_sym(7'h33, 7'h23); // 3 #
      7'h05: r = key_sym(7'h34, 7'h24); // 4 $
      7'h06: r = key_sym(7'h35, 7'h25); // 5 %
      7'h07: r = key_sym(7'h36, 7'h5E); // 6 ^
      7'h08: r = key_sym(7'h37, 7'h26); // 7 &
      7'h09: r = key_sym(7'h38, 7'h2A); // 8 *
      7'h0A: r = key_sym(7'h39, 7'h28); // 9 (
      7'h0B: r = key_sym(7'h30, 7'h29); // 0 )
      7'h0C: r = key_sym(7'h2D, 7'h5F); // - _
      7'h0D: r = key_sym(7'h3D, 7'h2B); // = +
      7'h0E: r = key_one(7'h08);        // backspace
      7'h0F: r = key_one(7'h09);        // tab
      7'h10: r = key_ltr(7'h71, 7'h51);
      7'h11: r = key_ltr(7'h77, 7'h57);
      7'h12: r = key_ltr(7'h65, 7'h45);
      7'h13: r = key_ltr(7'h72, 7'h52);
      7'h14: r = key_ltr(7'h74, 7'h54);
      7'h15: r = key_ltr(7'h79, 7'h59);
      7'h16: r = key_ltr(7'h75, 7'h55);
      7'h17: r = key_ltr(7'h69, 7'h49);
      7'h18: r = key_ltr(7'h6F, 7'h4F);
      7'h19: r = key_ltr(7'h70, 7'h50);
      7'h1A: r = key_sym(7'h5B, 7'h7B); // [ {
      7'h1B: r = key_sym(7'h5D, 7'h7D); // ] }
      7'h1C: r = key_one(7'h0A);        // enter
      7'h1E: r = key_ltr(7'h61, 7'h41);
      7'h1F: r = key_ltr(7'h73, 7'h53);
      7'h20: r = key_ltr(7'h64, 7'h44);
      7'h21: r = key_ltr(7'h66, 7'h46);
      7'h22: r = key_ltr(7'h67, 7'h47);
      7'h23: r = key_ltr(7'h68, 7'h48);
      7'h24: r = key_ltr(7'h6A, 7'h4A);
      7'h25: r = key_ltr(7'h6B, 7'h4B);
      7'h26: r = key_ltr(7'h6C, 7'h4C);
      7'h27: r = key_sym(7'h3B, 7'h3A); // ; :
      7'h28: r = key_sym(7'h27, 7'h22); // ' "
      7'h29: r = key_sym(7'h60, 7'h7E); // ` ~
      7'h2B: r = key_sym(7'h5C, 7'h7C); // \ |
      7'h2C: r = key_ltr(7'h7A, 7'h5A);
      7'h2D: r = key_ltr(7'h78, 7'h58);
      7'h2E: r = key_ltr(7'h63, 7'h43);
      7'h2F: r = key_ltr(7'h76, 7'h56);
      7'h30: r = key_ltr(7'h62, 7'h42);
      7'h31: r = key_ltr(7'h6E, 7'h4E);
      7'h32: r = key_ltr(7'h6D, 7'h4D);
      7'h33: r = key_sym(7'h2C, 7'h3C); // , <
      7'h34: r = key_sym(7'h2E, 7'h3E); // . >
      7'h35: r = key_sym(7'h2F, 7'h3F); // / ?
      7'h37: r = key_one(7'h2A);        // keypad *
      7'h39: r = key_one(7'h20);        // space
      7'h4A: r = key_one(7'h2D);        // keypad -
      7'h4E: r = key_one(7'h2B);        // keypad +
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

// ----- rtl/core/scd_front.sv -----
// Front end of the scancode decoder: accepts scancodes, tracks key state
// and caps lock, and turns presses into characters. Uses scd_pkg.
`default_nettype none

module scd_front
  import scd_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              s_tvalid,
  output      logic              s_tready,
  input  wire logic [CODE_W-1:0] s_tdata,
  input  wire logic              queue_full,
  output      char_item_t        push
);

  logic [KEY_COUNT-1:0] key_down;
  logic                 caps_lock;
  logic                 accept;
  logic                 press;
  logic [KEY_W-1:0]     key;
  logic                 shift;
  logic                 use_shifted;
  keymap_row_t          row;

  assign s_tready = !queue_full;
  assign accept   = s_tvalid && s_tready;
  assign key      = s_tdata[KEY_W-1:0];
  assign press    = !s_tdata[CODE_W-1];
  assign shift    = key_down[KEY_LSHIFT] || key_down[KEY_RSHIFT];

  always_comb begin
    row = keymap_lookup(key);
    if (row.is_letter) begin
      use_shifted = shift ^ caps_lock;
    end else begin
      use_shifted = shift && row.has_shift;
    end
    push.valid     = accept && press && row.is_char && (key != KEY_CAPS);
    push.character = use_shifted ? row.shifted : row.plain;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      key_down  <= '0;
      caps_lock <= 1'b0;
    end else if (accept) begin
      key_down[key] <= press;
      if (key == KEY_CAPS && !press) begin
        caps_lock <= !caps_lock;
      end
    end
  end

  a_caps_toggle: assert property (@(posedge clk) disable iff (rst)
    (accept && key == KEY_CAPS && !press) |=> (caps_lock != $past(caps_lock)))
    else $error("caps lock did not toggle on its release");

  a_no_push_full: assert property (@(posedge clk) disable iff (rst)
    push.valid |-> !queue_full)
    else $error("character pushed into a full queue");

  a_shift_tracks: assert property (@(posedge clk) disable iff (rst)
    (accept && key == KEY_LSHIFT) |=> (key_down[KEY_LSHIFT] == $past(press)))
    else $error("left shift state not recorded");

endmodule

`default_nettype wire

// ----- rtl/core/scd_queue.sv -----
// Short character queue between the decoder front and the output stage.
// Uses char_item_t from scd_pkg.
`default_nettype none

module scd_queue
  import scd_pkg::*;
#(
  parameter int unsigned QUEUE_DEPTH = DEF_QUEUE_DEPTH
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire char_item_t push,
  input  wire logic       pop,
  output      logic       full,
  output      char_item_t head
);

  localparam int unsigned PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(QUEUE_DEPTH);

  logic [CHAR_W-1:0] entries [QUEUE_DEPTH];
  logic [PTR_W-1:0]  wr_ptr;
  logic [PTR_W-1:0]  rd_ptr;
  logic [CNT_W-1:0]  count;
  logic              do_push;
  logic              do_pop;

  assign full           = (count == CNT_FULL);
  assign head.valid     = (count != '0);
  assign head.character = entries[rd_ptr];
  assign do_push        = push.valid && !full;
  assign do_pop         = pop && head.valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push.character;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_LAST) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_LAST) ? '0 : rd_ptr + PTR_W'(1);
      end
      case ({do_push, do_pop})
        2'b10:   count <= count + CNT_W'(1);
        2'b01:   count <= count - CNT_W'(1);
        default: count <= count;
      endcase
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_FULL)
    else $error("queue count beyond depth");

  a_pop_nonempty: assert property (@(posedge clk) disable iff (rst)
    pop |-> head.valid)
    else $error("pop from an empty queue");

  a_drain: assert property (@(posedge clk) disable iff (rst)
    (count == CNT_W'(1) && do_pop && !do_push) |=> !head.valid)
    else $error("queue not empty after last entry left");

endmodule

`default_nettype wire

// ----- rtl/core/scd_back.sv -----
// Output stage of the scancode decoder: registers characters from the
// queue onto the master stream. Uses char_item_t from scd_pkg.
`default_nettype none

module scd_back
  import scd_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire char_item_t        head,
  output      logic              pop,
  output      logic              m_tvalid,
  input  wire logic              m_tready,
  output      logic [CODE_W-1:0] m_tdata
);

  logic [CHAR_W-1:0] out_char;

  assign pop     = head.valid && (!m_tvalid || m_tready);
  assign m_tdata = {{(CODE_W - CHAR_W){1'b0}}, out_char};

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (!m_tvalid || m_tready) begin
      m_tvalid <= head.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      out_char <= head.character;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/core/scancode_to_ascii_decoder.sv -----
// Top level of the set-1 scancode to ASCII decoder.
// Instantiates scd_front, scd_queue and scd_back; uses scd_pkg.
//
//   channel | dir | bits of tdata                 | transfer when
//   --------+-----+-------------------------------+---------------------
//   s_*     | in  | [7:0] scancode (bit 7 release) | s_tvalid && s_tready
//   m_*     | out | [6:0] character, [7] zero      | m_tvalid && m_tready
//
// One scancode transfers per cycle while the queue is not full; the keymap
// lookup, key-state and caps lock update all happen in the cycle of the transfer.
// A character is written to a queue entry, then registered into out_char before
// it appears on m_tdata. Reset (rst, synchronous) clears the key-down map, caps
// lock, queue and output valid; no clearing pass follows.
// A stalled output holds its character while the queue (QUEUE_DEPTH deep)
// keeps taking characters; s_tready drops only when the queue is full.
`default_nettype none

module scancode_to_ascii_decoder
  import scd_pkg::*;
#(
  parameter int unsigned QUEUE_DEPTH = DEF_QUEUE_DEPTH
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              s_tvalid,
  output      logic              s_tready,
  input  wire logic [CODE_W-1:0] s_tdata,   // [7:0] scancode
  output      logic              m_tvalid,
  input  wire logic              m_tready,
  output      logic [CODE_W-1:0] m_tdata    // [6:0] character, [7] zero pad
);

  char_item_t push;
  char_item_t head;
  logic       queue_full;
  logic       pop;

  // Decode each scancode and push any resulting character.
  scd_front u_front (
    .clk        (clk),
    .rst        (rst),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .queue_full (queue_full),
    .push       (push)
  );

  // Buffer characters so the front keeps going while the output stalls.
  scd_queue #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk  (clk),
    .rst  (rst),
    .push (push),
    .pop  (pop),
    .full (queue_full),
    .head (head)
  );

  // Hold the current character on the master stream until it transfers.
  scd_back u_back (
    .clk      (clk),
    .rst      (rst),
    .head     (head),
    .pop      (pop),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

endmodule

`default_nettype wire

// ----- tb/testbench.sv -----
// Self-checking testbench for scancode_to_ascii_decoder.
// Holds a keyboard scoreboard class and the stream drivers; needs scd_pkg and
// the decoder RTL only.

// Tracks held keys and caps lock, and queues the characters the decoder owes.
class keyboard_scoreboard;
  typedef enum {KC_NONE, KC_PLAIN, KC_SYMBOL, KC_LETTER} key_class_t;

  key_class_t key_class[128];
  bit [6:0]   plain_char[128];
  bit [6:0]   shifted_char[128];
  bit [127:0] key_down;
  bit         caps_on;
  bit [6:0]   pending_chars[$];
  int         fail_count;

  function new();
    string num_plain;
    string num_shifted;
    string row_top;
    string row_home;
    string row_bottom;
    num_plain   = "1234567890-=";
    num_shifted = "!@#$%^&*()_+";
    row_top     = "qwertyuiop";
    row_home    = "asdfghjkl";
    row_bottom  = "zxcvbnm";
    foreach (key_class[k]) key_class[k] = KC_NONE;
    key_down   = '0;
    caps_on    = 1'b0;
    fail_count = 0;
    // Number row starts at key 0x02, the three letter rows at 0x10, 0x1E, 0x2C.
    for (int i = 0; i < num_plain.len(); i++)
      add_row(7'(32'h02 + i), KC_SYMBOL, num_plain[i], num_shifted[i]);
    for (int i = 0; i < row_top.len(); i++)
      add_row(7'(32'h10 + i), KC_LETTER, row_top[i], row_top[i] - 8'd32);
    for (int i = 0; i < row_home.len(); i++)
      add_row(7'(32'h1E + i), KC_LETTER, row_home[i], row_home[i] - 8'd32);
    for (int i = 0; i < row_bottom.len(); i++)
      add_row(7'(32'h2C + i), KC_LETTER, row_bottom[i], row_bottom[i] - 8'd32);
    add_row(7'h1A, KC_SYMBOL, "[", "{");
    add_row(7'h1B, KC_SYMBOL, "]", "}");
    add_row(7'h27, KC_SYMBOL, ";", ":");
    add_row(7'h28, KC_SYMBOL, 8'h27, 8'h22);  // quote, double quote
    add_row(7'h29, KC_SYMBOL, 8'h60, 8'h7E);  // backtick, tilde
    add_row(7'h2B, KC_SYMBOL, 8'h5C, "|");    // backslash, bar
    add_row(7'h33, KC_SYMBOL, ",", "<");
    add_row(7'h34, KC_SYMBOL, ".", ">");
    add_row(7'h35, KC_SYMBOL, "/", "?");
    // Keys with one symbol only ignore shift.
    add_row(7'h0E, KC_PLAIN, 8'h08, 8'h00);   // backspace
    add_row(7'h0F, KC_PLAIN, 8'h09, 8'h00);   // tab
    add_row(7'h1C, KC_PLAIN, 8'h0A, 8'h00);   // enter
    add_row(7'h37, KC_PLAIN, "*", 8'h00);     // keypad star
    add_row(7'h39, KC_PLAIN, " ", 8'h00);     // space
    add_row(7'h4A, KC_PLAIN, "-", 8'h00);     // keypad minus
    add_row(7'h4E, KC_PLAIN, "+", 8'h00);     // keypad plus
  endfunction

  function void add_row(bit [6:0] k, key_class_t cls, bit [7:0] p, bit [7:0] s);
    key_class[k]    = cls;
    plain_char[k]   = p[6:0];
    shifted_char[k] = s[6:0];
  endfunction

  // Apply one accepted scancode and queue the character it must produce.
  function void note_scancode(bit [7:0] code);
    bit [6:0] k;
    bit       press;
    bit       shift;
    bit [6:0] ch;
    k     = code[6:0];
    press = !code[7];
    key_down[k] = press;
    if (k == scd_pkg::KEY_CAPS) begin
      if (!press) caps_on = !caps_on;
      return;
    end
    if (!press || key_class[k] == KC_NONE) return;
    shift = key_down[scd_pkg::KEY_LSHIFT] | key_down[scd_pkg::KEY_RSHIFT];
    case (key_class[k])
      KC_LETTER: ch = (shift ^ caps_on) ? shifted_char[k] : plain_char[k];
      KC_SYMBOL: ch = shift ? shifted_char[k] : plain_char[k];
      default:   ch = plain_char[k];
    endcase
    pending_chars.push_back(ch);
  endfunction

  // Compare one output transfer with the oldest owed character.
  function void check_char(bit [7:0] tdata);
    bit [7:0] want;
    if (pending_chars.size() == 0) begin
      $display("%0t: unexpected character, expected none actual %h", $time, tdata);
      fail_count++;
      return;
    end
    want = {1'b0, pending_chars.pop_front()};
    if (tdata !== want) begin
      $display("%0t: character mismatch, expected %h actual %h", $time, want, tdata);
      fail_count++;
    end
  endfunction
endclass

module testbench;
  import scd_pkg::*;

  localparam int RANDOM_ITEMS = 1450;
  // Quiet cycles tolerated before declaring a hang: the limit covers sender gap
  // plus receiver stall plus queue drain.
  localparam int QUIET_LIMIT  = 400;
  // Settle time after the last owed character, to catch stray outputs.
  localparam int DRAIN_CYCLES = 30;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              s_tvalid = 1'b0;
  logic              s_tready;
  logic [CODE_W-1:0] s_tdata = '0;    // [7:0] scancode
  logic              m_tvalid;
  logic              m_tready = 1'b0;
  logic [CODE_W-1:0] m_tdata;         // [6:0] character, [7] zero pad

  keyboard_scoreboard sb;
  int sent_count  = 0;
  int send_run    = 0;
  int recv_run    = 0;
  int quiet_count = 0;

  scancode_to_ascii_decoder u_dut (
    .clk     (clk),
    .rst     (rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata (s_tdata),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Draw the idle cycles before the next transfer; now and then start a
  // stretch with no idling at all.
  function automatic int draw_gap(inout int run);
    if (run > 0) begin
      run--;
      return 0;
    end
    if ($urandom_range(0, 19) == 0) run = $urandom_range(10, 40);
    return $urandom_range(0, 11);
  endfunction

  // Mostly real keys, sometimes any key number including the unused range.
  function automatic bit [6:0] pick_key();
    if ($urandom_range(0, 9) == 0) return 7'($urandom_range(0, 127));
    return 7'($urandom_range(1, 8'h58));
  endfunction

  // Offer one scancode; keep tvalid high across back-to-back transfers and
  // return at the edge where the transfer happens.
  task automatic send_code(input bit [7:0] code);
    int gap;
    gap = draw_gap(send_run);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= code;
    do @(posedge clk); while (!s_tready);
    sent_count++;
  endtask

  task automatic tap_key(input bit [6:0] k);
    send_code({1'b0, k});
    // Hold the key long enough to repeat now and then.
    if ($urandom_range(0, 3) == 0) send_code({1'b0, k});
    send_code({1'b1, k});
  endtask

  // Sample both channels before the drivers update: inputs feed the
  // scoreboard, outputs are checked against it.
  always @(posedge clk) begin
    if (!rst) begin
      if (m_tvalid && m_tready) sb.check_char(m_tdata);
      if (s_tvalid && s_tready) sb.note_scancode(s_tdata);
    end
  end

  // Hang detection: count edges without any transfer on either channel.
  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      quiet_count <= 0;
    end else begin
      quiet_count <= quiet_count + 1;
    end
    if (quiet_count >= QUIET_LIMIT) begin
      $display("testbench NOT OK");
      $finish;
    end
  end

  // Receiver: stall tready for a random number of cycles before each transfer.
  initial begin
    int gap;
    while (rst) @(posedge clk);
    forever begin
      gap = draw_gap(recv_run);
      if (gap > 0) begin
        m_tready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      m_tready <= 1'b1;
      do @(posedge clk); while (!m_tvalid);
    end
  end

  initial begin
    bit [7:0] opening_codes[] = '{
      8'h00,                      // key zero: no character
      8'h1E, 8'h1E, 8'h9E,        // 'a' twice on repeat, then release
      8'h2A,                      // hold left shift
      8'h1E, 8'h02, 8'h0E, 8'h39, // 'A', '!', backspace and space ignore shift
      8'hAA,                      // drop left shift
      8'h3A, 8'hBA,               // caps lock toggles on release
      8'h10,                      // 'Q' from caps lock alone
      8'h36,                      // hold right shift
      8'h10, 8'h0C,               // shift with caps gives 'q'; '_'
      8'hB6,
      8'h4A, 8'h3B, 8'h59,        // keypad minus; F1 and unused keys are silent
      8'h7F, 8'hFF,               // top key press and release
      8'h3A, 8'hBA,               // caps lock back off
      8'h37                       // keypad star
    };
    int choice;
    int taps;
    bit [6:0] shift_key;

    sb = new();
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    foreach (opening_codes[i]) send_code(opening_codes[i]);

    // Mostly clean typing with random keys, shift chords and caps taps; the
    // rest is raw noise bytes.
    while (sent_count < opening_codes.size() + RANDOM_ITEMS) begin
      choice = $urandom_range(0, 99);
      if (choice < 50) begin
        tap_key(pick_key());
      end else if (choice < 68) begin
        shift_key = $urandom_range(0, 1) ? KEY_LSHIFT : KEY_RSHIFT;
        send_code({1'b0, shift_key});
        taps = $urandom_range(1, 4);
        repeat (taps) tap_key(pick_key());
        if ($urandom_range(0, 4) != 0) send_code({1'b1, shift_key});
      end else if (choice < 78) begin
        send_code({1'b0, KEY_CAPS});
        send_code({1'b1, KEY_CAPS});
      end else begin
        send_code(8'($urandom_range(0, 255)));
      end
    end
    s_tvalid <= 1'b0;

    // Drain owed characters, then give stray outputs a chance to show.
    while (sb.pending_chars.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (sb.fail_count == 0) begin
      $display("testbench OK");
    end else begin
      $display("testbench NOT OK");
    end
    $finish;
  end
endmodule
